// File: hdl/bnlc_pkg.sv
// ----------------------------------------------------------------------------
// bnlc_pkg
// Types, constants and helper functions shared by the node location cache.
// ----------------------------------------------------------------------------
package bnlc_pkg;

  // geometry
  localparam int unsigned BLOCK_BITS   = 6;
  localparam int unsigned ID_BITS      = 20;
  localparam int unsigned SLOT_BITS    = 6;
  localparam int unsigned SLOT_COUNT   = 2 ** SLOT_BITS;
  localparam int unsigned SPARSE_BITS  = 12;
  localparam int unsigned SPARSE_DEPTH = 2 ** SPARSE_BITS;
  localparam int unsigned BLK_BITS     = ID_BITS - BLOCK_BITS;
  localparam int unsigned BLOCK_COUNT  = 2 ** BLK_BITS;
  localparam int unsigned PER_BLOCK    = 2 ** BLOCK_BITS;
  localparam int unsigned LOC_AW       = SLOT_BITS + BLOCK_BITS;
  localparam int unsigned USED_W       = SLOT_BITS + 1;
  localparam int unsigned FILL_W       = BLOCK_BITS + 1;
  localparam int unsigned CNT_W        = SPARSE_BITS + 1;
  localparam int unsigned BUDGET_W     = 24;
  localparam int unsigned BUSED_W      = BUDGET_W + 1;
  localparam int unsigned MAXD_W       = 7;
  localparam int unsigned MAXS_W       = 13;
  localparam int unsigned LOC_W        = 64;
  localparam int unsigned SP_W         = ID_BITS + LOC_W;
  localparam int unsigned BLOCK_BYTES  = PER_BLOCK * 8;
  localparam int unsigned TUPLE_BYTES  = 16;

  localparam logic [LOC_W-1:0] NO_LOC = 64'h7FFF_FFFF_7FFF_FFFF;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;
  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;

  // command codes
  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // status codes
  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_RANGE  = 3'd1;
  localparam logic [2:0] STAT_ORDER  = 3'd2;
  localparam logic [2:0] STAT_FULL   = 3'd3;
  localparam logic [2:0] STAT_NOMODE = 3'd4;
  localparam logic [2:0] STAT_DROP   = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_DENSE   = 3'd0;
  localparam logic [2:0] CFG_SPARSE  = 3'd1;
  localparam logic [2:0] CFG_LOSSY   = 3'd2;
  localparam logic [2:0] CFG_BUDGET  = 3'd3;
  localparam logic [2:0] CFG_MAXD    = 3'd4;
  localparam logic [2:0] CFG_MAXS    = 3'd5;

  typedef struct packed {
    logic                dense_enable;
    logic                sparse_enable;
    logic                lossy_enable;
    logic [BUDGET_W-1:0] cache_budget;
    logic [MAXD_W-1:0]   max_dense_blocks;
    logic [MAXS_W-1:0]   max_sparse_entries;
  } cfg_t;

  typedef struct packed {
    logic                      command;
    logic signed [ID_BITS-1:0] node_id;
    logic signed [31:0]        node_lon;
    logic signed [31:0]        node_lat;
  } in_t;

  typedef struct packed {
    logic signed [31:0] found_lon;
    logic signed [31:0] found_lat;
    logic               hit;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic res_valid;
    logic order_warn;
    out_t res;
  } core_stat_t;

  typedef enum logic [5:0] {
    CS_CLEAR, CS_IDLE, CS_START, CS_FIN,
    CS_D_MAP, CS_D_CHK, CS_D_FILL, CS_D_PREV, CS_D_PFILL, CS_D_WR,
    CS_M_OWN, CS_M_RD, CS_M_CHK, CS_M_END,
    CS_B_CLR, CS_R_HEAP, CS_E_TOP, CS_E_HEAP, CS_E_OWN,
    CS_P_TOP, CS_P_A, CS_P_B, CS_P_C, CS_P_D,
    CS_S_TOP, CS_S_A, CS_S_B, CS_S_C, CS_S_D, CS_S_E,
    CS_L_MAP, CS_L_LOC, CS_L_SP, CS_BS_TOP, CS_BS_CMP
  } state_e;

  // a location counts when both coordinates are in range
  function automatic logic loc_valid(input logic [LOC_W-1:0] l);
    logic signed [31:0] lon;
    logic signed [31:0] lat;
    lon = signed'(l[31:0]);
    lat = signed'(l[63:32]);
    return (lon >= -LON_MAX) && (lon <= LON_MAX) && (lat >= -LAT_MAX) && (lat <= LAT_MAX);
  endfunction

  // block number of an id, sign bit flipped so blocks sort by id
  function automatic logic [BLK_BITS-1:0] blk_of(input logic [ID_BITS-1:0] id);
    return {~id[ID_BITS-1], id[ID_BITS-2:BLOCK_BITS]};
  endfunction

  // id of an offset within a block
  function automatic logic [ID_BITS-1:0] id_of(input logic [BLK_BITS-1:0] blk,
                                               input logic [BLOCK_BITS-1:0] off);
    return {~blk[BLK_BITS-1], blk[BLK_BITS-2:0], off};
  endfunction

  // admission check of one sparse table append
  function automatic logic [2:0] sp_code(input logic signed [ID_BITS-1:0] id,
                                         input logic signed [ID_BITS-1:0] last,
                                         input logic [CNT_W-1:0] cnt,
                                         input logic [CNT_W-1:0] cap,
                                         input logic [BUSED_W-1:0] bused,
                                         input logic [BUSED_W-1:0] budget);
    if ((last != '0) && (id < last)) return STAT_ORDER;
    if ((cnt >= cap) || (bused > budget)) return STAT_FULL;
    return STAT_OK;
  endfunction

endpackage

// File: hdl/bnlc_ram.sv
// ----------------------------------------------------------------------------
// bnlc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bnlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bnlc_core.sv
// ----------------------------------------------------------------------------
// bnlc_core
// Sequencer of the location cache: block map, slot memory, slot heap and
// sparse table, worked one request at a time.
// ----------------------------------------------------------------------------
module bnlc_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bnlc_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  input  bnlc_pkg::in_t          in_data_i,
  output logic                   in_ready_o,
  input  logic                   res_ready_i,
  output bnlc_pkg::core_stat_t   stat_o
);
  import bnlc_pkg::*;

  state_e state_q, state_d, ret_q;

  // request and working registers
  logic                      cmd_q;
  logic signed [ID_BITS-1:0] id_q;
  logic [LOC_W-1:0]          loc_q, got_q;
  logic [2:0]                status_q;
  logic [SLOT_BITS-1:0]      slot_q, pos_q, alt_q, idx_q_unused_guard;
  logic [BLOCK_BITS-1:0]     idx_q;
  logic [BLK_BITS-1:0]       owner_q, clr_q;
  logic [FILL_W-1:0]         fill_q, fa_q, fb_q;
  logic [SLOT_BITS-1:0]      ha_q, hb_q, hc_q;
  logic [CNT_W-1:0]          lo_q, hi_q, mid_q;
  logic                      evict_q;

  // persistent state
  logic [USED_W-1:0]         used_q;
  logic [CNT_W-1:0]          scnt_q;
  logic signed [ID_BITS-1:0] last_q;
  logic [BUSED_W-1:0]        bused_q;
  logic                      warn_q;

  // memory ports
  logic                  map_we, loc_we, own_we, fill_we, heap_we, sp_we;
  logic [BLK_BITS-1:0]   map_wa, map_ra, own_wd, own_rd;
  logic [SLOT_BITS:0]    map_wd, map_rd;
  logic [LOC_AW-1:0]     loc_wa, loc_ra;
  logic [LOC_W-1:0]      loc_wd, loc_rd;
  logic [SLOT_BITS-1:0]  own_wa, own_ra, fill_wa, fill_ra, heap_wa, heap_ra;
  logic [SLOT_BITS-1:0]  heap_wd, heap_rd;
  logic [FILL_W-1:0]     fill_wd, fill_rd;
  logic [SPARSE_BITS-1:0] sp_wa, sp_ra;
  logic [SP_W-1:0]       sp_wd, sp_rd;

  // derived values
  logic [BLK_BITS-1:0]       blk;
  logic [BLOCK_BITS-1:0]     off;
  logic [USED_W-1:0]         maxb;
  logic [CNT_W-1:0]          cap;
  logic [BUSED_W-1:0]        budget;
  logic                      room, budget_zero;
  logic [SLOT_BITS-1:0]      m_slot, exp_pos, ch_idx, ch_h;
  logic [FILL_W-1:0]         ch_f, fill_inc;
  logic [7:0]                c1w, c2w;
  logic                      sift_go, pick1, perc_after, idx_last;
  logic signed [ID_BITS-1:0] mig_id, sp_rd_id;
  logic [2:0]                mig_code, in_code;
  logic                      mig_ok;
  logic [CNT_W-1:0]          bs_mid;
  logic [BUSED_W-1:0]        bused_sub;

  assign idx_q_unused_guard = idx_q;

  assign blk         = blk_of(id_q);
  assign off         = id_q[BLOCK_BITS-1:0];
  assign maxb        = (cfg_i.max_dense_blocks > MAXD_W'(SLOT_COUNT)) ?
                       USED_W'(SLOT_COUNT) : USED_W'(cfg_i.max_dense_blocks);
  assign cap         = (cfg_i.max_sparse_entries > MAXS_W'(SPARSE_DEPTH)) ?
                       CNT_W'(SPARSE_DEPTH) : CNT_W'(cfg_i.max_sparse_entries);
  assign budget      = BUSED_W'(cfg_i.cache_budget);
  assign budget_zero = (cfg_i.cache_budget == '0);
  assign room        = (used_q < maxb) && (bused_q < budget);
  assign m_slot      = SLOT_BITS'(map_rd - 1'b1);
  assign exp_pos     = room ? SLOT_BITS'(used_q - 1'b1) : '0;
  assign idx_last    = (idx_q == '1);

  // sift-down child selection
  assign c1w     = {1'b0, pos_q, 1'b1};
  assign c2w     = {1'b0, pos_q, 1'b0} + 8'd2;
  assign sift_go = (c1w < (8'(used_q) - 8'd1)) && (c2w < 8'(SLOT_COUNT));
  assign pick1   = (fb_q <= fill_rd);
  assign ch_idx  = pick1 ? c1w[SLOT_BITS-1:0] : c2w[SLOT_BITS-1:0];
  assign ch_h    = pick1 ? hb_q : hc_q;
  assign ch_f    = pick1 ? fb_q : fill_rd;

  assign fill_inc   = (fill_q < FILL_W'(PER_BLOCK)) ? fill_q + 1'b1 : fill_q;
  assign perc_after = ((used_q + 1'b1) == maxb) ||
                      ((bused_q + BUSED_W'(BLOCK_BYTES)) > budget);
  assign bused_sub  = (bused_q >= BUSED_W'(BLOCK_BYTES)) ?
                      bused_q - BUSED_W'(BLOCK_BYTES) : '0;

  // sparse table append checks
  assign mig_id   = signed'(id_of(owner_q, idx_q));
  assign mig_ok   = loc_valid(loc_rd);
  assign mig_code = sp_code(mig_id, last_q, scnt_q, cap, bused_q, budget);
  assign in_code  = sp_code(id_q, last_q, scnt_q, cap, bused_q, budget);

  assign bs_mid   = lo_q + ((hi_q - lo_q) >> 1);
  assign sp_rd_id = signed'(sp_rd[SP_W-1:LOC_W]);

  // memories
  bnlc_ram #(.WIDTH(SLOT_BITS + 1), .DEPTH(BLOCK_COUNT)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_wa), .wdata_i(map_wd),
    .raddr_i(map_ra), .rdata_o(map_rd));
  bnlc_ram #(.WIDTH(LOC_W), .DEPTH(SLOT_COUNT * PER_BLOCK)) u_loc (
    .clk_i, .we_i(loc_we), .waddr_i(loc_wa), .wdata_i(loc_wd),
    .raddr_i(loc_ra), .rdata_o(loc_rd));
  bnlc_ram #(.WIDTH(BLK_BITS), .DEPTH(SLOT_COUNT)) u_owner (
    .clk_i, .we_i(own_we), .waddr_i(own_wa), .wdata_i(own_wd),
    .raddr_i(own_ra), .rdata_o(own_rd));
  bnlc_ram #(.WIDTH(FILL_W), .DEPTH(SLOT_COUNT)) u_fill (
    .clk_i, .we_i(fill_we), .waddr_i(fill_wa), .wdata_i(fill_wd),
    .raddr_i(fill_ra), .rdata_o(fill_rd));
  bnlc_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOT_COUNT)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_wa), .wdata_i(heap_wd),
    .raddr_i(heap_ra), .rdata_o(heap_rd));
  bnlc_ram #(.WIDTH(SP_W), .DEPTH(SPARSE_DEPTH)) u_sparse (
    .clk_i, .we_i(sp_we), .waddr_i(sp_wa), .wdata_i(sp_wd),
    .raddr_i(sp_ra), .rdata_o(sp_rd));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_CLEAR:   if (clr_q == '1) state_d = CS_IDLE;
      CS_IDLE:    if (in_valid_i) state_d = CS_START;
      CS_START: begin
        if (budget_zero) begin
          state_d = CS_FIN;
        end else if (cmd_q == CMD_STORE) begin
          if (cfg_i.dense_enable && (maxb != '0)) state_d = CS_D_MAP;
          else state_d = CS_FIN;
        end else if (cfg_i.dense_enable) begin
          state_d = CS_L_MAP;
        end else if (cfg_i.sparse_enable) begin
          state_d = CS_BS_TOP;
        end else begin
          state_d = CS_FIN;
        end
      end
      CS_D_MAP: begin
        if (map_rd != '0) begin
          state_d = (used_q == '0) ? CS_FIN : CS_D_CHK;
        end else if (room) begin
          state_d = (used_q == '0) ? CS_B_CLR : CS_D_PREV;
        end else begin
          state_d = (!cfg_i.lossy_enable || used_q == '0) ? CS_FIN : CS_S_TOP;
        end
      end
      CS_D_CHK:   state_d = (heap_rd != slot_q) ? CS_FIN : CS_D_FILL;
      CS_D_FILL:  state_d = CS_D_WR;
      CS_D_PREV:  state_d = CS_D_PFILL;
      CS_D_PFILL: state_d = (!cfg_i.sparse_enable || fill_rd > FILL_W'(PER_BLOCK / 2)) ?
                            CS_P_TOP : CS_M_OWN;
      CS_M_OWN:   state_d = CS_M_RD;
      CS_M_RD:    state_d = CS_M_CHK;
      CS_M_CHK:   state_d = idx_last ? CS_M_END : CS_M_RD;
      CS_M_END:   state_d = CS_B_CLR;
      CS_B_CLR:   if (idx_last) state_d = evict_q ? CS_D_WR : CS_R_HEAP;
      CS_R_HEAP:  state_d = perc_after ? CS_P_TOP : CS_D_WR;
      CS_E_TOP:   state_d = CS_E_HEAP;
      CS_E_HEAP:  state_d = CS_E_OWN;
      CS_E_OWN:   state_d = CS_B_CLR;
      CS_D_WR:    state_d = CS_FIN;
      CS_P_TOP:   state_d = (pos_q == '0) ? ret_q : CS_P_A;
      CS_P_A:     state_d = CS_P_B;
      CS_P_B:     state_d = CS_P_C;
      CS_P_C:     state_d = (fa_q < fill_rd) ? CS_P_D : ret_q;
      CS_P_D:     state_d = CS_P_TOP;
      CS_S_TOP:   state_d = sift_go ? CS_S_A : ret_q;
      CS_S_A:     state_d = CS_S_B;
      CS_S_B:     state_d = CS_S_C;
      CS_S_C:     state_d = CS_S_D;
      CS_S_D:     state_d = (fa_q > ch_f) ? CS_S_E : ret_q;
      CS_S_E:     state_d = CS_S_TOP;
      CS_L_MAP:   state_d = (map_rd != '0) ? CS_L_LOC : CS_L_SP;
      CS_L_LOC:   state_d = CS_L_SP;
      CS_L_SP:    state_d = (cfg_i.sparse_enable && !loc_valid(got_q)) ? CS_BS_TOP : CS_FIN;
      CS_BS_TOP:  state_d = (lo_q < hi_q) ? CS_BS_CMP : CS_FIN;
      CS_BS_CMP:  state_d = (sp_rd_id == id_q) ? CS_FIN : CS_BS_TOP;
      CS_FIN:     if (res_ready_i) state_d = CS_IDLE;
      default:    state_d = CS_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    map_we  = 1'b0;  map_wa  = clr_q;  map_wd  = '0;  map_ra = blk;
    loc_we  = 1'b0;  loc_wa  = {slot_q, idx_q};  loc_wd = NO_LOC;
    loc_ra  = {slot_q, idx_q};
    own_we  = 1'b0;  own_wa  = slot_q; own_wd  = blk;
    own_ra  = (state_q == CS_E_HEAP) ? heap_rd : slot_q;
    fill_we = 1'b0;  fill_wa = slot_q; fill_wd = '0; fill_ra = slot_q;
    heap_we = 1'b0;  heap_wa = pos_q;  heap_wd = slot_q; heap_ra = pos_q;
    sp_we   = 1'b0;  sp_wa   = scnt_q[SPARSE_BITS-1:0];
    sp_wd   = {id_q, loc_q};
    sp_ra   = bs_mid[SPARSE_BITS-1:0];
    case (state_q)
      CS_CLEAR: map_we = 1'b1;
      CS_START: begin
        if (!budget_zero && cmd_q == CMD_STORE && !cfg_i.dense_enable &&
            cfg_i.sparse_enable && in_code == STAT_OK) begin
          sp_we = 1'b1;
        end
      end
      CS_D_MAP:   heap_ra = (map_rd != '0) ? exp_pos : SLOT_BITS'(used_q - 1'b1);
      CS_D_PREV:  fill_ra = heap_rd;
      CS_M_CHK: begin
        sp_we = mig_ok && (mig_code == STAT_OK);
        sp_wd = {mig_id, loc_rd};
      end
      CS_M_END: begin
        map_we = 1'b1;
        map_wa = owner_q;
      end
      CS_B_CLR: begin
        loc_we = 1'b1;
        if (idx_last) begin
          map_we  = 1'b1;
          map_wa  = blk;
          map_wd  = {1'b0, slot_q} + 1'b1;
          own_we  = 1'b1;
          fill_we = 1'b1;
        end
      end
      CS_R_HEAP: begin
        heap_we = 1'b1;
        heap_wa = used_q[SLOT_BITS-1:0];
      end
      CS_E_TOP:   heap_ra = '0;
      CS_E_OWN: begin
        map_we = 1'b1;
        map_wa = own_rd;
      end
      CS_D_WR: begin
        loc_we  = 1'b1;
        loc_wa  = {slot_q, off};
        loc_wd  = loc_q;
        fill_we = 1'b1;
        fill_wd = fill_inc;
      end
      CS_P_A: begin
        fill_ra = heap_rd;
        heap_ra = alt_q;
      end
      CS_P_B:     fill_ra = heap_rd;
      CS_P_C: begin
        heap_we = (fa_q < fill_rd);
        heap_wd = hb_q;
      end
      CS_P_D, CS_S_E: begin
        heap_we = 1'b1;
        heap_wa = alt_q;
        heap_wd = ha_q;
      end
      CS_S_A: begin
        fill_ra = heap_rd;
        heap_ra = c1w[SLOT_BITS-1:0];
      end
      CS_S_B: begin
        fill_ra = heap_rd;
        heap_ra = c2w[SLOT_BITS-1:0];
      end
      CS_S_C:     fill_ra = heap_rd;
      CS_S_D: begin
        heap_we = (fa_q > ch_f);
        heap_wd = ch_h;
      end
      CS_L_MAP:   loc_ra = {m_slot, off};
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // persistent control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      used_q  <= '0;
      scnt_q  <= '0;
      last_q  <= '0;
      bused_q <= '0;
      warn_q  <= 1'b1;
      idx_q   <= '0;
    end else begin
      case (state_q)
        CS_CLEAR: clr_q <= clr_q + 1'b1;
        CS_START: begin
          if (!budget_zero && cmd_q == CMD_STORE && !cfg_i.dense_enable &&
              cfg_i.sparse_enable && in_code == STAT_OK) begin
            scnt_q  <= scnt_q + 1'b1;
            last_q  <= id_q;
            bused_q <= bused_q + BUSED_W'(TUPLE_BYTES);
          end
        end
        CS_D_MAP: if (map_rd != '0 && used_q == '0) warn_q <= 1'b0;
        CS_D_CHK: if (heap_rd != slot_q) warn_q <= 1'b0;
        CS_M_CHK: begin
          idx_q <= idx_q + 1'b1;
          if (mig_ok && mig_code == STAT_OK) begin
            scnt_q  <= scnt_q + 1'b1;
            last_q  <= mig_id;
            bused_q <= bused_q + BUSED_W'(TUPLE_BYTES);
          end
        end
        CS_M_END: begin
          used_q  <= used_q - 1'b1;
          bused_q <= bused_sub;
        end
        CS_B_CLR: idx_q <= idx_q + 1'b1;
        CS_R_HEAP: begin
          used_q  <= used_q + 1'b1;
          bused_q <= bused_q + BUSED_W'(BLOCK_BYTES);
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ret_q   <= CS_IDLE;
      evict_q <= 1'b0;
    end else begin
      case (state_q)
        CS_D_MAP: begin
          if (map_rd == '0 && room) begin
            evict_q <= 1'b0;
          end else if (map_rd == '0) begin
            evict_q <= 1'b1;
            ret_q   <= CS_E_TOP;
          end
        end
        CS_D_PFILL: ret_q <= CS_B_CLR;
        CS_R_HEAP:  ret_q <= CS_D_WR;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        cmd_q    <= in_data_i.command;
        id_q     <= in_data_i.node_id;
        loc_q    <= {in_data_i.node_lat, in_data_i.node_lon};
        got_q    <= NO_LOC;
        status_q <= STAT_OK;
      end
      CS_START: begin
        lo_q <= '0;
        hi_q <= scnt_q;
        if (cmd_q == CMD_STORE) begin
          if (budget_zero) begin
            status_q <= STAT_DROP;
          end else if (cfg_i.dense_enable) begin
            if (maxb == '0) status_q <= STAT_DROP;
          end else if (cfg_i.sparse_enable) begin
            status_q <= (in_code != STAT_OK && cfg_i.lossy_enable) ? STAT_DROP : in_code;
          end else begin
            status_q <= STAT_NOMODE;
          end
        end else if (!budget_zero && !cfg_i.dense_enable && !cfg_i.sparse_enable) begin
          status_q <= STAT_NOMODE;
        end
      end
      CS_D_MAP: begin
        if (map_rd != '0) begin
          slot_q <= m_slot;
          if (used_q == '0) status_q <= STAT_DROP;
        end else if (room) begin
          slot_q <= '0;
        end else if (!cfg_i.lossy_enable) begin
          status_q <= STAT_FULL;
        end else if (used_q == '0) begin
          status_q <= STAT_DROP;
        end else begin
          pos_q <= '0;
        end
      end
      CS_D_CHK:   if (heap_rd != slot_q) status_q <= STAT_DROP;
      CS_D_FILL:  fill_q <= fill_rd;
      CS_D_PREV:  slot_q <= heap_rd;
      CS_D_PFILL: begin
        if (!cfg_i.sparse_enable || fill_rd > FILL_W'(PER_BLOCK / 2)) begin
          slot_q <= used_q[SLOT_BITS-1:0];
          pos_q  <= SLOT_BITS'(used_q - 1'b1);
        end
      end
      CS_M_OWN:   owner_q <= own_rd;
      CS_M_CHK: begin
        if (mig_ok && mig_code != STAT_OK && !cfg_i.lossy_enable &&
            status_q == STAT_OK) begin
          status_q <= mig_code;
        end
      end
      CS_E_HEAP:  slot_q <= heap_rd;
      CS_B_CLR:   if (idx_last) fill_q <= '0;
      CS_R_HEAP:  pos_q <= used_q[SLOT_BITS-1:0];
      CS_P_TOP:   alt_q <= SLOT_BITS'((pos_q - 1'b1) >> 1);
      CS_P_A:     ha_q <= heap_rd;
      CS_P_B: begin
        fa_q <= fill_rd;
        hb_q <= heap_rd;
      end
      CS_P_D:     pos_q <= alt_q;
      CS_S_A:     ha_q <= heap_rd;
      CS_S_B: begin
        fa_q <= fill_rd;
        hb_q <= heap_rd;
      end
      CS_S_C: begin
        fb_q <= fill_rd;
        hc_q <= heap_rd;
      end
      CS_S_D:     alt_q <= ch_idx;
      CS_S_E:     pos_q <= alt_q;
      CS_L_LOC:   got_q <= loc_rd;
      CS_L_SP: begin
        lo_q <= '0;
        hi_q <= scnt_q;
      end
      CS_BS_TOP: begin
        if (lo_q < hi_q) mid_q <= bs_mid;
        else got_q <= NO_LOC;
      end
      CS_BS_CMP: begin
        if (sp_rd_id == id_q) got_q <= sp_rd[LOC_W-1:0];
        else if (sp_rd_id < id_q) lo_q <= mid_q + 1'b1;
        else hi_q <= mid_q;
      end
      default: ;
    endcase
  end

  // handshake and result
  assign in_ready_o                = (state_q == CS_IDLE);
  assign stat_o.res_valid          = (state_q == CS_FIN);
  assign stat_o.order_warn         = warn_q;
  assign stat_o.res.found_lon      = signed'(got_q[31:0]);
  assign stat_o.res.found_lat      = signed'(got_q[63:32]);
  assign stat_o.res.hit            = loc_valid(got_q);
  assign stat_o.res.status         = status_q;

endmodule

// File: hdl/block_node_location_cache.sv
// ----------------------------------------------------------------------------
// block_node_location_cache
// Location store keyed by signed node id, with dense slot blocks, a fill
// count heap for eviction and a sorted sparse table.
// ----------------------------------------------------------------------------
// After reset the block map is cleared in a pass over every entry, during
// which no request is taken; configuration writes are taken at any time.
// One request is worked at a time: a lookup reads the block map and slot
// memory and, failing that, binary-searches the sparse table; a store goes
// into the open block, opening a block adds a slot clear and a sift of the
// heap, and moving a thin block into the sparse table adds a pass over its
// entries. A finished result waits in the output register while the next
// request is taken.
module block_node_location_cache (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bnlc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bnlc_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [23:0]     cfg_wdata_i
);
  import bnlc_pkg::*;

  cfg_t       cfg_q;
  core_stat_t core_st;
  logic       res_ready;
  logic       out_valid_q;
  out_t       out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dense_enable       <= 1'b1;
      cfg_q.sparse_enable      <= 1'b1;
      cfg_q.lossy_enable       <= 1'b1;
      cfg_q.cache_budget       <= BUDGET_W'(65536);
      cfg_q.max_dense_blocks   <= MAXD_W'(64);
      cfg_q.max_sparse_entries <= MAXS_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DENSE:  cfg_q.dense_enable       <= cfg_wdata_i[0];
        CFG_SPARSE: cfg_q.sparse_enable      <= cfg_wdata_i[0];
        CFG_LOSSY:  cfg_q.lossy_enable       <= cfg_wdata_i[0];
        CFG_BUDGET: cfg_q.cache_budget       <= cfg_wdata_i[BUDGET_W-1:0];
        CFG_MAXD:   cfg_q.max_dense_blocks   <= cfg_wdata_i[MAXD_W-1:0];
        CFG_MAXS:   cfg_q.max_sparse_entries <= cfg_wdata_i[MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  bnlc_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i,
    .in_data_i,
    .in_ready_o,
    .res_ready_i (res_ready),
    .stat_o      (core_st)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= core_st.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && core_st.res_valid) begin
      out_q <= core_st.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // core only takes a request with no result pending
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !core_st.res_valid)
    else $error("request taken while a result is pending");

  // a result the output register cannot take is held
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_st.res_valid && !res_ready |=> core_st.res_valid && $stable(core_st.res))
    else $error("pending result lost");

  // a hit always comes with an ok status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.status == STAT_OK)
    else $error("hit with error status");

  // clearing the order warning goes with a dropped store
  a_warn_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(core_st.order_warn) |-> core_st.res_valid && core_st.res.status == STAT_DROP)
    else $error("order warning cleared without a drop");

endmodule
